// File: hdl/stsu_pkg.sv
// ----------------------------------------------------------------------------
// stsu_pkg
// Shared types and constants of the periodic-event / countdown timer unit.
// ----------------------------------------------------------------------------
package stsu_pkg;

   // default sizes
   localparam int unsigned EVENT_SLOTS_DEF = 8;
   localparam int unsigned COUNTDOWNS_DEF  = 8;

   // command codes
   localparam logic [2:0] CMD_TICK     = 3'd0;
   localparam logic [2:0] CMD_REGISTER = 3'd1;
   localparam logic [2:0] CMD_REMOVE   = 3'd2;
   localparam logic [2:0] CMD_ALLOC    = 3'd3;
   localparam logic [2:0] CMD_READ     = 3'd4;
   localparam logic [2:0] CMD_RELEASE  = 3'd5;
   localparam logic [2:0] CMD_LOAD     = 3'd6;

   localparam logic [7:0]  PRESCALE_RESET = 8'd100;
   localparam logic [7:0]  CD_FREE        = 8'hff;
   localparam logic [15:0] MIN_INTERVAL   = 16'd10;
   // x / 10 == (x * 52429) >> 19 for every 16-bit x
   localparam logic [15:0] DIV10_RECIP    = 16'd52429;
   localparam int unsigned DIV10_SHIFT    = 19;
   localparam int unsigned PERIOD_W       = 13;

   typedef struct packed {
      logic [7:0]          owner;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] count;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT_RD,
      ST_SLOT_WR,
      ST_CD_RD,
      ST_CD_WR,
      ST_DONE
   } state_type;

endpackage

// File: hdl/soft_timer_slot_unit.sv
// ----------------------------------------------------------------------------
// soft_timer_slot_unit
// Periodic-event slots and countdown timers kept in two small memories.
// ----------------------------------------------------------------------------
// One command word is taken at a time. Slot and countdown state sit in two
// synchronous memories; each entry visited is read, then modified/written.
// A tick walks all EVENT_SLOTS slots and, on a prescale hit, all COUNTDOWNS
// countdowns. Register and remove walk all slots, allocate all countdowns;
// read visits only the entry its handle names (none with a bad handle);
// release, load and unknown commands go straight to the closing step. Slot
// steps and the closing word wait while the result side stalls. A tick
// returns one word per firing slot and a closing word with last set; every
// other command returns one word. Memory contents are qualified by per-entry
// valid bits, so no clearing pass follows reset.
module soft_timer_slot_unit #(
   parameter int unsigned EVENT_SLOTS = stsu_pkg::EVENT_SLOTS_DEF,
   parameter int unsigned COUNTDOWNS  = stsu_pkg::COUNTDOWNS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_callback_id,
   input  logic [15:0] req_interval_ms,
   input  logic [7:0]  req_timer_handle,
   input  logic [7:0]  req_load_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_fired,
   output logic [7:0]  rsp_fired_id,
   output logic        rsp_ok,
   output logic [7:0]  rsp_handle,
   output logic [7:0]  rsp_value,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int unsigned SIW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
   localparam int unsigned CIW = (COUNTDOWNS > 1) ? $clog2(COUNTDOWNS) : 1;
   localparam int unsigned PW  = stsu_pkg::PERIOD_W;

   stsu_pkg::state_type state_ff, state_in;

   // memories and their valid bits
   stsu_pkg::slot_type slot_mem [EVENT_SLOTS];
   stsu_pkg::slot_type slot_rd_ff;
   logic [EVENT_SLOTS-1:0] slot_vld_ff;
   logic [7:0] cd_mem [COUNTDOWNS];
   logic [7:0] cd_rd_ff;
   logic [COUNTDOWNS-1:0] cd_vld_ff;

   // command word and scan state
   logic [2:0]     cmd_ff;
   logic [7:0]     id_ff;
   logic [15:0]    ivl_ff;
   logic [7:0]     ld_ff;
   logic           hvalid_ff;
   logic           hit_ff;
   logic [7:0]     prescale_ff;
   logic [7:0]     pcount_ff;
   logic [SIW-1:0] slot_idx_ff;
   logic [CIW-1:0] cd_idx_ff;
   logic           found_ff, found_in;
   logic           free_ff, free_in;
   logic [SIW-1:0] slot_pick_ff, slot_pick_in;
   logic [CIW-1:0] cd_pick_ff, cd_pick_in;
   logic [7:0]     val_ff, val_in;

   // result register
   logic       rsp_valid_ff;
   logic       rsp_fired_ff, rsp_ok_ff, rsp_last_ff;
   logic [7:0] rsp_fired_id_ff, rsp_handle_ff, rsp_value_ff;
   logic       rsp_load;
   logic       rsp_fired_in, rsp_ok_in, rsp_last_in;
   logic [7:0] rsp_fired_id_in, rsp_handle_in, rsp_value_in;

   // memory write controls
   logic               slot_we, slot_clr;
   logic [SIW-1:0]     slot_wa;
   stsu_pkg::slot_type slot_wd;
   logic               cd_we;
   logic [CIW-1:0]     cd_wa;
   logic [7:0]         cd_wd;

   logic               accept, go;
   logic               hvalid;
   logic [CIW-1:0]     hidx;
   logic               slot_last, cd_last;
   stsu_pkg::slot_type slot_eff;
   logic [7:0]         cd_eff;
   logic               slot_match, slot_fire;
   logic [31:0]        prod;
   logic [PW-1:0]      new_period;

   assign accept    = req_valid && (state_ff == stsu_pkg::ST_IDLE);
   assign req_stall = (state_ff != stsu_pkg::ST_IDLE);
   assign go        = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign hvalid = (req_timer_handle != 8'd0) && (req_timer_handle <= 8'(COUNTDOWNS));
   assign hidx   = CIW'(req_timer_handle - 8'd1);

   assign slot_last = (slot_idx_ff == SIW'(EVENT_SLOTS - 1));
   assign cd_last   = (cd_idx_ff == CIW'(COUNTDOWNS - 1));

   // entries never written read as their reset values
   assign slot_eff   = slot_vld_ff[slot_idx_ff] ? slot_rd_ff : '0;
   assign cd_eff     = cd_vld_ff[cd_idx_ff] ? cd_rd_ff : stsu_pkg::CD_FREE;
   assign slot_match = (slot_eff.owner == id_ff);
   assign slot_fire  = (slot_eff.owner != 8'd0) && (slot_eff.count == slot_eff.period);

   // period = max(interval, 10) / 10 by reciprocal multiply
   assign prod       = 32'(ivl_ff) * 32'(stsu_pkg::DIV10_RECIP);
   assign new_period = prod[stsu_pkg::DIV10_SHIFT +: PW];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stsu_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  stsu_pkg::CMD_TICK, stsu_pkg::CMD_REGISTER, stsu_pkg::CMD_REMOVE:
                     state_in = stsu_pkg::ST_SLOT_RD;
                  stsu_pkg::CMD_ALLOC: state_in = stsu_pkg::ST_CD_RD;
                  stsu_pkg::CMD_READ:
                     state_in = hvalid ? stsu_pkg::ST_CD_RD : stsu_pkg::ST_DONE;
                  default: state_in = stsu_pkg::ST_DONE;
               endcase
            end
         end
         stsu_pkg::ST_SLOT_RD: state_in = stsu_pkg::ST_SLOT_WR;
         stsu_pkg::ST_SLOT_WR: begin
            if (go) begin
               if (!slot_last)
                  state_in = stsu_pkg::ST_SLOT_RD;
               else if (cmd_ff == stsu_pkg::CMD_TICK && hit_ff)
                  state_in = stsu_pkg::ST_CD_RD;
               else
                  state_in = stsu_pkg::ST_DONE;
            end
         end
         stsu_pkg::ST_CD_RD: state_in = stsu_pkg::ST_CD_WR;
         stsu_pkg::ST_CD_WR: begin
            if (cmd_ff == stsu_pkg::CMD_READ || cd_last)
               state_in = stsu_pkg::ST_DONE;
            else
               state_in = stsu_pkg::ST_CD_RD;
         end
         stsu_pkg::ST_DONE: if (go) state_in = stsu_pkg::ST_IDLE;
         default: state_in = stsu_pkg::ST_IDLE;
      endcase
   end

   // datapath, memory writes and result words
   always_comb begin
      found_in        = found_ff;
      free_in         = free_ff;
      slot_pick_in    = slot_pick_ff;
      cd_pick_in      = cd_pick_ff;
      val_in          = val_ff;
      slot_we         = 1'b0;
      slot_clr        = 1'b0;
      slot_wa         = slot_idx_ff;
      slot_wd         = slot_eff;
      cd_we           = 1'b0;
      cd_wa           = cd_idx_ff;
      cd_wd           = cd_eff;
      rsp_load        = 1'b0;
      rsp_fired_in    = 1'b0;
      rsp_fired_id_in = 8'd0;
      rsp_ok_in       = 1'b1;
      rsp_handle_in   = 8'd0;
      rsp_value_in    = 8'd0;
      rsp_last_in     = 1'b0;
      case (state_ff)
         stsu_pkg::ST_SLOT_WR: begin
            if (go) begin
               if (cmd_ff == stsu_pkg::CMD_TICK) begin
                  if (slot_eff.owner != 8'd0) begin
                     slot_we = 1'b1;
                     slot_wd.count = slot_fire ? '0 : slot_eff.count + PW'(1);
                  end
                  if (slot_fire) begin
                     rsp_load        = 1'b1;
                     rsp_fired_in    = 1'b1;
                     rsp_fired_id_in = slot_eff.owner;
                  end
               end else begin
                  // register: duplicate id; remove: first match
                  if (slot_match && !found_ff) begin
                     found_in     = 1'b1;
                     slot_pick_in = slot_idx_ff;
                  end
                  if (slot_eff.owner == 8'd0 && !free_ff) begin
                     free_in = 1'b1;
                     if (cmd_ff == stsu_pkg::CMD_REGISTER)
                        slot_pick_in = slot_idx_ff;
                  end
                  if (cmd_ff == stsu_pkg::CMD_REGISTER)
                     slot_pick_in = (slot_eff.owner == 8'd0 && !free_ff) ? slot_idx_ff
                                                                        : slot_pick_ff;
               end
            end
         end
         stsu_pkg::ST_CD_WR: begin
            case (cmd_ff)
               stsu_pkg::CMD_TICK: begin
                  if (cd_eff != stsu_pkg::CD_FREE && cd_eff != 8'd0) begin
                     cd_we = 1'b1;
                     cd_wd = cd_eff - 8'd1;
                  end
               end
               stsu_pkg::CMD_ALLOC: begin
                  if (cd_eff == stsu_pkg::CD_FREE && !free_ff) begin
                     free_in    = 1'b1;
                     cd_pick_in = cd_idx_ff;
                  end
               end
               default: val_in = cd_eff;
            endcase
         end
         stsu_pkg::ST_DONE: begin
            if (go) begin
               rsp_load    = 1'b1;
               rsp_last_in = 1'b1;
               case (cmd_ff)
                  stsu_pkg::CMD_TICK: rsp_ok_in = 1'b1;
                  stsu_pkg::CMD_REGISTER: begin
                     rsp_ok_in = found_ff || free_ff;
                     if (!found_ff && free_ff) begin
                        slot_we = 1'b1;
                        slot_wa = slot_pick_ff;
                        slot_wd = '{owner: id_ff, period: new_period, count: '0};
                     end
                  end
                  stsu_pkg::CMD_REMOVE: begin
                     rsp_ok_in = found_ff;
                     slot_clr  = found_ff;
                     slot_wa   = slot_pick_ff;
                  end
                  stsu_pkg::CMD_ALLOC: begin
                     rsp_ok_in     = free_ff;
                     rsp_handle_in = free_ff ? 8'(cd_pick_ff) + 8'd1 : 8'd0;
                     cd_we         = free_ff;
                     cd_wa         = cd_pick_ff;
                     cd_wd         = 8'd0;
                  end
                  stsu_pkg::CMD_READ: begin
                     rsp_ok_in    = hvalid_ff;
                     rsp_value_in = hvalid_ff ? val_ff : 8'd0;
                  end
                  stsu_pkg::CMD_RELEASE, stsu_pkg::CMD_LOAD: begin
                     rsp_ok_in = hvalid_ff;
                     cd_we     = hvalid_ff;
                     cd_wa     = cd_idx_ff;
                     cd_wd     = (cmd_ff == stsu_pkg::CMD_LOAD) ? ld_ff : stsu_pkg::CD_FREE;
                  end
                  default: rsp_ok_in = 1'b0;
               endcase
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stsu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prescale_ff  <= stsu_pkg::PRESCALE_RESET;
         pcount_ff    <= 8'd0;
         slot_vld_ff  <= '0;
         cd_vld_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
         if (csr_valid) prescale_ff <= csr_data;
         if (accept && req_cmd == stsu_pkg::CMD_TICK)
            pcount_ff <= (pcount_ff == prescale_ff) ? 8'd0 : pcount_ff + 8'd1;
         if (slot_we) slot_vld_ff[slot_wa] <= 1'b1;
         if (slot_clr) slot_vld_ff[slot_wa] <= 1'b0;
         if (cd_we) cd_vld_ff[cd_wa] <= 1'b1;
      end
   end

   // command word, scan pointers and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff       <= req_cmd;
         id_ff        <= req_callback_id;
         ivl_ff       <= (req_interval_ms < stsu_pkg::MIN_INTERVAL) ? stsu_pkg::MIN_INTERVAL
                                                                    : req_interval_ms;
         ld_ff        <= req_load_value;
         hvalid_ff    <= hvalid;
         hit_ff       <= (pcount_ff == prescale_ff);
         slot_idx_ff  <= '0;
         // handle commands start at their entry, scans at the first one
         cd_idx_ff    <= (hvalid && req_cmd inside {stsu_pkg::CMD_READ, stsu_pkg::CMD_RELEASE,
                                                    stsu_pkg::CMD_LOAD}) ? hidx : '0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         slot_pick_ff <= '0;
         cd_pick_ff   <= '0;
         val_ff       <= 8'd0;
      end else begin
         found_ff     <= found_in;
         free_ff      <= free_in;
         slot_pick_ff <= slot_pick_in;
         cd_pick_ff   <= cd_pick_in;
         val_ff       <= val_in;
         if (state_ff == stsu_pkg::ST_SLOT_WR && go && !slot_last)
            slot_idx_ff <= slot_idx_ff + SIW'(1);
         if (state_ff == stsu_pkg::ST_CD_WR && !cd_last && cmd_ff != stsu_pkg::CMD_READ)
            cd_idx_ff <= cd_idx_ff + CIW'(1);
      end
      if (rsp_load) begin
         rsp_fired_ff    <= rsp_fired_in;
         rsp_fired_id_ff <= rsp_fired_id_in;
         rsp_ok_ff       <= rsp_ok_in;
         rsp_handle_ff   <= rsp_handle_in;
         rsp_value_ff    <= rsp_value_in;
         rsp_last_ff     <= rsp_last_in;
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      slot_rd_ff <= slot_mem[slot_idx_ff];
   end

   // countdown memory
   always_ff @(posedge clock) begin
      if (cd_we) cd_mem[cd_wa] <= cd_wd;
      cd_rd_ff <= cd_mem[cd_idx_ff];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_fired    = rsp_fired_ff;
   assign rsp_fired_id = rsp_fired_id_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_handle   = rsp_handle_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_last     = rsp_last_ff;

   // checks
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> (state_ff == stsu_pkg::ST_IDLE))
      else $error("closing word not followed by idle");

   a_fire_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fired_ff) |-> (rsp_fired_id_ff != 8'd0 && !rsp_last_ff))
      else $error("fire notice with free id or last set");

   a_fire_on_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_fired_in) |-> (cmd_ff == stsu_pkg::CMD_TICK))
      else $error("fire notice outside a tick");

endmodule
